@@ rtl/sample_without_replacement_top_assert.svh @@
// Assertion macros used by the checker file swr_chk.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef SAMPLE_WITHOUT_REPLACEMENT_TOP_ASSERT_SVH
`define SAMPLE_WITHOUT_REPLACEMENT_TOP_ASSERT_SVH

// Same-cycle implication.
`define SWR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication.
`define SWR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

@@ rtl/swr_pkg.sv @@
// ---------------------------------------------------------------------------
// swr_pkg
// Shared constants, types and helpers of the sampling-without-replacement
// block.
// ---------------------------------------------------------------------------
package swr_pkg;

	localparam int POOL_DEPTH = 256;
	localparam int POOL_AW    = $clog2(POOL_DEPTH);
	localparam int CNT_W      = 9;
	localparam int FRAC_W     = 16;
	localparam int PROD_W     = FRAC_W + CNT_W;
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 3;

	localparam logic [CNT_W-1:0] POOL_SIZE_RST  = CNT_W'(256);
	localparam logic [CNT_W-1:0] PICK_COUNT_RST = CNT_W'(1);

	// Register indexes (paddr[2])
	localparam logic REG_POOL_SIZE  = 1'b0;
	localparam logic REG_PICK_COUNT = 1'b1;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [CNT_W-1:0] pool_size;
		logic [CNT_W-1:0] pick_count;
		logic             restart;
		logic [CNT_W-1:0] n_next;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_busy;
	} dp_status_t;

	// Clip the pool size to the physical pool depth
	function automatic logic [CNT_W-1:0] sat_pool(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = (v > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : v;
		return r;
	endfunction

endpackage

@@ rtl/swr_cfg.sv @@
// ---------------------------------------------------------------------------
// swr_cfg
// APB register file: pool size and pick count, with a restart pulse on
// every write.
// ---------------------------------------------------------------------------
module swr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swr_pkg::APB_AW-1:0]    paddr,
	input  logic [swr_pkg::APB_DW-1:0]    pwdata,
	output logic [swr_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	output swr_pkg::cfg_t                 cfg
);

	logic [swr_pkg::CNT_W-1:0] pool_size_q;
	logic [swr_pkg::CNT_W-1:0] pick_count_q;
	logic [swr_pkg::CNT_W-1:0] pool_size_d;
	logic                      wr_en;
	logic [swr_pkg::CNT_W-1:0] wdata;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign wdata  = pwdata[swr_pkg::CNT_W-1:0];

	always_comb begin
		pool_size_d = pool_size_q;
		if (wr_en && paddr[2] == swr_pkg::REG_POOL_SIZE) begin
			pool_size_d = wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q  <= swr_pkg::POOL_SIZE_RST;
			pick_count_q <= swr_pkg::PICK_COUNT_RST;
		end else if (wr_en) begin
			case (paddr[2])
				swr_pkg::REG_POOL_SIZE:  pool_size_q  <= wdata;
				swr_pkg::REG_PICK_COUNT: pick_count_q <= wdata;
				default:                 pool_size_q  <= pool_size_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			swr_pkg::REG_POOL_SIZE:
				prdata = {{(swr_pkg::APB_DW-swr_pkg::CNT_W){1'b0}}, pool_size_q};
			swr_pkg::REG_PICK_COUNT:
				prdata = {{(swr_pkg::APB_DW-swr_pkg::CNT_W){1'b0}}, pick_count_q};
			default:
				prdata = '0;
		endcase
	end

	assign cfg.pool_size  = pool_size_q;
	assign cfg.pick_count = pick_count_q;
	assign cfg.restart    = wr_en;
	// live size that takes effect at the write edge
	assign cfg.n_next     = swr_pkg::sat_pool(pool_size_d);

endmodule

@@ rtl/swr_ctrl.sv @@
// ---------------------------------------------------------------------------
// swr_ctrl
// Draw sequencer: take a word, read the pool, then commit the draw once the
// output register is free.
// ---------------------------------------------------------------------------
module swr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  swr_pkg::dp_status_t   status,
	output swr_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic {
		S_IDLE,
		S_DRAW
	} state_t;

	state_t state_q;

	assign in_stall   = (state_q != S_IDLE);
	assign cmd.accept = (state_q == S_IDLE) && in_valid;
	assign cmd.commit = (state_q == S_DRAW) && !status.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DRAW;
				end
				S_DRAW: begin
					// hold until the previous result is taken
					if (!status.out_busy) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/swr_dp.sv @@
// ---------------------------------------------------------------------------
// swr_dp
// Datapath: pool memory with per-entry valid bits, live and drawn counters,
// index multiplier and output register.
// ---------------------------------------------------------------------------
module swr_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  swr_pkg::cfg_t                cfg,
	input  swr_pkg::ctrl_cmd_t           cmd,
	output swr_pkg::dp_status_t          status,
	input  logic [swr_pkg::FRAC_W-1:0]   random_fraction,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [swr_pkg::CNT_W-1:0]    chosen_item,
	output logic                         round_last,
	output logic                         error
);

	localparam int AW = swr_pkg::POOL_AW;
	localparam int CW = swr_pkg::CNT_W;

	logic [CW-1:0]                 pool_mem [swr_pkg::POOL_DEPTH];
	logic [swr_pkg::POOL_DEPTH-1:0] valid_q;
	logic [CW-1:0]                 rem_q;
	logic [CW-1:0]                 drawn_q;
	logic                          out_valid_q;
	logic [CW-1:0]                 item_q;
	logic                          last_q;
	logic                          err_q;

	logic [AW-1:0] idx_s1;
	logic [AW-1:0] tail_s1;
	logic [CW-1:0] rd_a_s1;
	logic [CW-1:0] rd_b_s1;
	logic          va_s1;
	logic          vb_s1;
	logic          err_s1;

	logic [CW-1:0]                n_eff;
	logic [CW-1:0]                k_cnt;
	logic                         bad_c;
	logic [swr_pkg::PROD_W-1:0]   prod;
	logic [AW-1:0]                idx_c;
	logic [CW-1:0]                rem_m1;
	logic [AW-1:0]                tail_c;
	logic [CW-1:0]                item_c;
	logic [CW-1:0]                moved_c;
	logic [CW:0]                  drawn_p1;
	logic                         last_c;
	logic                         draw_ok;

	assign n_eff = swr_pkg::sat_pool(cfg.pool_size);
	assign k_cnt = cfg.pick_count;
	assign bad_c = (n_eff == '0) || (k_cnt == '0) || (k_cnt > n_eff) ||
	               (rem_q == '0) || (rem_q > n_eff);

	// index = (fraction * live count) >> FRAC_W, always below the live count
	assign prod   = swr_pkg::PROD_W'(random_fraction) * swr_pkg::PROD_W'(rem_q);
	assign idx_c  = prod[swr_pkg::FRAC_W +: AW];
	assign rem_m1 = rem_q - CW'(1);
	assign tail_c = rem_m1[AW-1:0];

	// untouched entries read as their identity value
	assign item_c  = va_s1 ? rd_a_s1 : CW'(idx_s1) + CW'(1);
	assign moved_c = vb_s1 ? rd_b_s1 : CW'(tail_s1) + CW'(1);

	assign drawn_p1 = {1'b0, drawn_q} + (CW+1)'(1);
	assign last_c   = (drawn_p1 >= {1'b0, k_cnt});
	assign draw_ok  = cmd.commit && !err_s1;

	// pool memory: two registered reads at accept, one write at a commit without error
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_a_s1 <= pool_mem[idx_c];
			rd_b_s1 <= pool_mem[tail_c];
			va_s1   <= valid_q[idx_c];
			vb_s1   <= valid_q[tail_c];
			idx_s1  <= idx_c;
			tail_s1 <= tail_c;
			err_s1  <= bad_c;
		end
		if (draw_ok) begin
			pool_mem[idx_s1] <= moved_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rem_q   <= CW'(swr_pkg::POOL_DEPTH);
			drawn_q <= '0;
		end else if (cfg.restart) begin
			valid_q <= '0;
			rem_q   <= cfg.n_next;
			drawn_q <= '0;
		end else if (draw_ok) begin
			if (last_c) begin
				// round done: back to the identity pool
				valid_q <= '0;
				rem_q   <= n_eff;
				drawn_q <= '0;
			end else begin
				valid_q[idx_s1] <= 1'b1;
				rem_q           <= rem_m1;
				drawn_q         <= drawn_p1[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			item_q      <= '0;
			last_q      <= 1'b0;
			err_q       <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
			item_q      <= err_s1 ? '0 : item_c;
			last_q      <= !err_s1 && last_c;
			err_q       <= err_s1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_busy = out_valid_q && out_stall;
	assign out_valid       = out_valid_q;
	assign chosen_item     = item_q;
	assign round_last      = last_q;
	assign error           = err_q;

endmodule

@@ rtl/sample_without_replacement_top.sv @@
// A taken input word reads the pool into registers at accept; its result
// word is registered in the output register at commit. No new word is taken
// before that commit, set by the dependent write-back of the moved tail entry.
// A stalled output holds the sequencer in its draw state until taken.
// Reset: pool_size 256, pick_count 1, identity pool via cleared valid bits,
// no clearing pass; the block takes words straight out of reset.
// ---------------------------------------------------------------------------
// sample_without_replacement_top
// Draws pick_count distinct items from 1..pool_size (clipped to 256) by partial Fisher-Yates.
// ---------------------------------------------------------------------------
module sample_without_replacement_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [swr_pkg::APB_AW-1:0]   paddr,
	input  logic [swr_pkg::APB_DW-1:0]   pwdata,
	output logic [swr_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [swr_pkg::FRAC_W-1:0]   random_fraction,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [swr_pkg::CNT_W-1:0]    chosen_item,
	output logic                         round_last,
	output logic                         error
);

	swr_pkg::cfg_t       cfg;
	swr_pkg::ctrl_cmd_t  cmd;
	swr_pkg::dp_status_t status;

	swr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	swr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	swr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.status          (status),
		.random_fraction (random_fraction),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.chosen_item     (chosen_item),
		.round_last      (round_last),
		.error           (error)
	);

endmodule

@@ rtl/swr_chk.sv @@
// ---------------------------------------------------------------------------
// swr_chk
// Port-level checker for the sampling block, bound to the top level.
// ---------------------------------------------------------------------------
`include "sample_without_replacement_top_assert.svh"

module swr_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [swr_pkg::CNT_W-1:0]    chosen_item,
	input logic                         round_last,
	input logic                         error
);

	// one word at a time: busy right after a take
	`SWR_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

	// an error word carries no item and never closes a round
	`SWR_ASSERT_NOW(a_err_clean, out_valid && error, chosen_item == '0 && !round_last)

	// a real draw never returns item zero
	`SWR_ASSERT_NOW(a_item_nonzero, out_valid && !error, chosen_item != '0)

	// stalled result holds
	`SWR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(chosen_item) && $stable(round_last) && $stable(error))

endmodule

bind sample_without_replacement_top swr_chk u_swr_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.chosen_item (chosen_item),
	.round_last  (round_last),
	.error       (error)
);
